// ===== rtl/tbs_pkg.sv =====
`default_nettype none
package tbs_pkg;

  // Coordinate format
  localparam int COORD_FRACTION_BITS = 16;
  localparam int COORD_W = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;

  // Length and unit vector
  localparam int LEN_W     = 34;
  localparam int RAD_W     = 2 * LEN_W;
  localparam int SQ_REM_W  = LEN_W + 2;
  localparam int UNIT_W    = 31;
  localparam int UNIT_FRAC = 30;
  localparam int UNUM_W    = DIFF_W + UNIT_FRAC;
  localparam int OUT_UNIT_W = 32;

  // Stiffness path
  localparam int CFG_W       = 32;
  localparam int EA_W        = 2 * CFG_W;
  localparam int EA_LO_W     = EA_W / 2;
  localparam int MU_W        = 2 * UNIT_W;
  localparam int MU_LO_W     = MU_W / 2;
  localparam int PP_W        = EA_LO_W + MU_W - MU_LO_W;
  localparam int PROD_W      = EA_W + MU_W;
  localparam int STIFF_W     = 64;
  localparam int STIFF_SHIFT = 60 - COORD_FRACTION_BITS;
  localparam int QN_W        = PROD_W - STIFF_SHIFT;
  localparam int QTOP_W      = QN_W - STIFF_W;
  localparam int DIV_W       = STIFF_W;

  // Cell counts
  localparam int SQ_CELLS    = LEN_W;
  localparam int UNIT_CELLS  = UNIT_W;
  localparam int STIFF_CELLS = STIFF_W;

  // Pipeline positions
  localparam int K_IN    = 0;
  localparam int K_ABS   = 1;
  localparam int K_SQR   = 2;
  localparam int K_SQ0   = 3;
  localparam int K_LEN   = K_SQ0 + SQ_CELLS;
  localparam int K_UNIT  = K_LEN + 1 + UNIT_CELLS;
  localparam int K_MU    = K_UNIT + 1;
  localparam int K_STIFF = K_MU + 3 + STIFF_CELLS + 1;
  localparam int K_OUT   = K_STIFF + 1;

  // Stream widths
  localparam int IN_DATA_W  = 4 * COORD_W;
  localparam int OUT_FIELD_W = LEN_W + 2 * OUT_UNIT_W + 3 * STIFF_W;
  localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FIELD_W;
  localparam int OUT_USER_W = 2;

  // Register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA    = 1'b1;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [LEN_W-1:0]    root;
    logic [RAD_W-1:0]    rad;
  } sqrt_t;

  typedef struct packed {
    logic [LEN_W-1:0] rem;
    logic [LEN_W-1:0] dvs;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        ax;
    logic [DIFF_W-1:0]        ay;
    logic                     sx;
    logic                     sy;
    logic                     zero;
    logic [LEN_W-1:0]         len;
    logic [UNIT_W-1:0]        cm;
    logic [UNIT_W-1:0]        sm;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/tbs_sqrt_cell.sv =====
`default_nettype none
module tbs_sqrt_cell (
  input  wire logic          clk,
  input  wire logic          en,
  input  tbs_pkg::sqrt_t     din,
  output tbs_pkg::sqrt_t     dout
);
  import tbs_pkg::*;

  logic [SQ_REM_W+1:0] acc;
  logic [SQ_REM_W+1:0] trial;
  logic                fit;

  // one root bit: bring down two radicand bits, try root*4+1
  always_comb begin
    acc   = {din.rem, din.rad[RAD_W-1 -: 2]};
    trial = {{(SQ_REM_W-LEN_W){1'b0}}, din.root, 2'b01};
    fit   = (acc >= trial);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem  <= fit ? SQ_REM_W'(acc - trial) : SQ_REM_W'(acc);
      dout.root <= {din.root[LEN_W-2:0], fit};
      dout.rad  <= din.rad << 2;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tbs_div_cell.sv =====
`default_nettype none
module tbs_div_cell (
  input  wire logic      clk,
  input  wire logic      en,
  input  tbs_pkg::div_t  din,
  output tbs_pkg::div_t  dout
);
  import tbs_pkg::*;

  logic [LEN_W:0] acc;
  logic [LEN_W:0] dvs_ext;
  logic           fit;

  // one quotient bit of restoring division
  always_comb begin
    acc     = {din.rem, din.num[DIV_W-1]};
    dvs_ext = {1'b0, din.dvs};
    fit     = (acc >= dvs_ext);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.rem <= fit ? LEN_W'(acc - dvs_ext) : LEN_W'(acc);
      dout.dvs <= din.dvs;
      dout.num <= din.num << 1;
      dout.quo <= {din.quo[DIV_W-2:0], fit};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tbs_unit_lane.sv =====
`default_nettype none
module tbs_unit_lane (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [tbs_pkg::DIFF_W-1:0]  mag,
  input  wire logic [tbs_pkg::LEN_W-1:0]   len,
  output logic      [tbs_pkg::UNIT_W-1:0]  unit
);
  import tbs_pkg::*;

  logic [UNUM_W-1:0] numer;
  div_t              chain [0:UNIT_CELLS];

  // mag * 2^30 + len/2, rounds the quotient half up
  always_comb begin
    numer = (UNUM_W'(mag) << UNIT_FRAC) + UNUM_W'(len >> 1);
  end

  // top bits already lie below len since the quotient fits UNIT_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].rem <= LEN_W'(numer >> UNIT_W);
      chain[0].dvs <= len;
      chain[0].num <= {numer[UNIT_W-1:0], {(DIV_W-UNIT_W){1'b0}}};
      chain[0].quo <= '0;
    end
  end

  for (genvar i = 0; i < UNIT_CELLS; i++) begin : g_cell
    tbs_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  assign unit = chain[UNIT_CELLS].quo[UNIT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/tbs_stiff_lane.sv =====
`default_nettype none
module tbs_stiff_lane (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [tbs_pkg::EA_W-1:0]     ea,
  input  wire logic [tbs_pkg::MU_W-1:0]     mu,
  input  wire logic [tbs_pkg::LEN_W-1:0]    len,
  input  wire logic                         neg,
  output logic      [tbs_pkg::STIFF_W-1:0]  value,
  output logic                              sat
);
  import tbs_pkg::*;

  logic [PP_W-1:0]    pp00, pp01, pp10, pp11;
  logic [LEN_W-1:0]   len1, len2;
  logic               neg1, neg2;
  logic [PROD_W-1:0]  prod;
  logic [QN_W-1:0]    qn;
  logic               ovf_now;
  div_t               chain [0:STIFF_CELLS];
  logic               ovf_d [0:STIFF_CELLS];
  logic               neg_d [0:STIFF_CELLS];
  logic [STIFF_W-1:0] quo;
  logic [STIFF_W-1:0] limit;
  logic               over;
  logic [STIFF_W-1:0] mag;

  // partial products of ea * mu
  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= PP_W'(ea[EA_LO_W-1:0]) * PP_W'(mu[MU_LO_W-1:0]);
      pp01 <= PP_W'(ea[EA_LO_W-1:0]) * PP_W'(mu[MU_W-1:MU_LO_W]);
      pp10 <= PP_W'(ea[EA_W-1:EA_LO_W]) * PP_W'(mu[MU_LO_W-1:0]);
      pp11 <= PP_W'(ea[EA_W-1:EA_LO_W]) * PP_W'(mu[MU_W-1:MU_LO_W]);
      len1 <= len;
      neg1 <= neg;
    end
  end

  // sum and drop the fixed part of the divisor
  always_comb begin
    prod = PROD_W'(pp00) + (PROD_W'(pp01) << MU_LO_W) + (PROD_W'(pp10) << EA_LO_W)
         + (PROD_W'(pp11) << (MU_LO_W + EA_LO_W));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qn   <= QN_W'(prod >> STIFF_SHIFT);
      len2 <= len1;
      neg2 <= neg1;
    end
  end

  // quotient would need more than STIFF_W bits
  assign ovf_now = (LEN_W'(qn[QN_W-1:STIFF_W]) >= len2);

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].rem <= ovf_now ? '0 : LEN_W'(qn[QN_W-1:STIFF_W]);
      chain[0].dvs <= len2;
      chain[0].num <= qn[STIFF_W-1:0];
      chain[0].quo <= '0;
      ovf_d[0]     <= ovf_now;
      neg_d[0]     <= neg2;
    end
  end

  for (genvar i = 0; i < STIFF_CELLS; i++) begin : g_cell
    tbs_div_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_d[i+1] <= ovf_d[i];
        neg_d[i+1] <= neg_d[i];
      end
    end
  end

  // clip, then apply sign
  always_comb begin
    quo   = chain[STIFF_CELLS].quo;
    limit = neg_d[STIFF_CELLS] ? {1'b1, {(STIFF_W-1){1'b0}}} : {1'b0, {(STIFF_W-1){1'b1}}};
    over  = ovf_d[STIFF_CELLS] || (quo > limit);
    mag   = over ? limit : quo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= neg_d[STIFF_CELLS] ? (~mag + STIFF_W'(1)) : mag;
      sat   <= over;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/truss_bar_stiffness_core.sv =====
`default_nettype none
// Channel   | Direction | Signals                           | Carries
// s_*       | in        | s_tvalid s_tready s_tdata          | one bar: two end points
// m_*       | out       | m_tvalid m_tready m_tdata m_tuser  | length, unit vector, stiffness
// cfg_*     | in        | cfg_valid cfg_ready cfg_index/data | modulus and area registers
//
// One bar per cycle while the output does not stall.
// Most pipeline stages lie in the cell chains: 34 square-root cells, 31 cells for the
// unit vector division and 64 cells for the stiffness division.
// All stages advance together; when m_tready is low with a result waiting, the
// whole pipeline holds and s_tready drops. rst clears the valid bits and the configuration registers.
module truss_bar_stiffness_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [tbs_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // bar_length, cosine, sine, stiff_xx, stiff_xy, stiff_yy, zero pad
  output logic      [tbs_pkg::OUT_DATA_W-1:0]    m_tdata,
  // zero_length, saturated
  output logic      [tbs_pkg::OUT_USER_W-1:0]    m_tuser,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbs_pkg::CFG_W-1:0]         cfg_data
);
  import tbs_pkg::*;

  logic                     en;
  logic                     vld [0:K_OUT];
  side_t                    side [0:K_STIFF];
  side_t                    side_in [0:K_STIFF];
  logic [CFG_W-1:0]         modulus, area;
  logic [EA_W-1:0]          ea;
  logic [SQ_W-1:0]          x2, y2;
  sqrt_t                    sq [0:SQ_CELLS];
  logic [UNIT_W-1:0]        cm_lane, sm_lane;
  logic [MU_W-1:0]          mu_cc, mu_cs, mu_ss;
  logic [STIFF_W-1:0]       k_xx, k_xy, k_yy;
  logic                     sat_xx, sat_xy, sat_yy;
  logic [LEN_W-1:0]         o_len;
  logic [OUT_UNIT_W-1:0]    o_cos, o_sin;
  logic [STIFF_W-1:0]       o_xx, o_xy, o_yy;
  logic                     o_zero, o_sat;

  assign en        = !vld[K_OUT] || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers and their product
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= '0;
      area    <= '0;
      ea      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODULUS: modulus <= cfg_data;
          CFG_AREA:    area    <= cfg_data;
        endcase
      end
      ea <= EA_W'(modulus) * EA_W'(area);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= K_OUT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= K_OUT; k++) vld[k] <= vld[k-1];
    end
  end

  // side data, updated where its stage computes it
  always_comb begin
    side_in[0]    = '0;
    side_in[0].dx = {s_tdata[3*COORD_W-1], s_tdata[3*COORD_W-1:2*COORD_W]}
                  - {s_tdata[COORD_W-1], s_tdata[COORD_W-1:0]};
    side_in[0].dy = {s_tdata[4*COORD_W-1], s_tdata[4*COORD_W-1:3*COORD_W]}
                  - {s_tdata[2*COORD_W-1], s_tdata[2*COORD_W-1:COORD_W]};
    for (int k = 1; k <= K_STIFF; k++) begin
      side_in[k] = side[k-1];
      if (k == K_ABS) begin
        side_in[k].sx   = side[k-1].dx[DIFF_W-1];
        side_in[k].sy   = side[k-1].dy[DIFF_W-1];
        side_in[k].ax   = side[k-1].dx[DIFF_W-1] ? DIFF_W'(-side[k-1].dx) : side[k-1].dx;
        side_in[k].ay   = side[k-1].dy[DIFF_W-1] ? DIFF_W'(-side[k-1].dy) : side[k-1].dy;
        side_in[k].zero = (side[k-1].dx == '0) && (side[k-1].dy == '0);
      end
      if (k == K_LEN + 1) side_in[k].len = sq[SQ_CELLS].root;
      if (k == K_MU) begin
        side_in[k].cm = cm_lane;
        side_in[k].sm = sm_lane;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= K_STIFF; k++) side[k] <= side_in[k];
    end
  end

  // squares, then the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      x2         <= SQ_W'(side[K_ABS].ax) * SQ_W'(side[K_ABS].ax);
      y2         <= SQ_W'(side[K_ABS].ay) * SQ_W'(side[K_ABS].ay);
      sq[0].rad  <= RAD_W'(x2) + RAD_W'(y2);
      sq[0].rem  <= '0;
      sq[0].root <= '0;
    end
  end

  // square root chain
  for (genvar j = 0; j < SQ_CELLS; j++) begin : g_sqrt
    tbs_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq[j]),
      .dout (sq[j+1])
    );
  end

  // direction cosine and sine
  tbs_unit_lane u_cos (
    .clk  (clk),
    .en   (en),
    .mag  (side[K_LEN].ax),
    .len  (sq[SQ_CELLS].root),
    .unit (cm_lane)
  );

  tbs_unit_lane u_sin (
    .clk  (clk),
    .en   (en),
    .mag  (side[K_LEN].ay),
    .len  (sq[SQ_CELLS].root),
    .unit (sm_lane)
  );

  // products of the unit vector
  always_ff @(posedge clk) begin
    if (en) begin
      mu_cc <= MU_W'(cm_lane) * MU_W'(cm_lane);
      mu_cs <= MU_W'(cm_lane) * MU_W'(sm_lane);
      mu_ss <= MU_W'(sm_lane) * MU_W'(sm_lane);
    end
  end

  tbs_stiff_lane u_kxx (
    .clk   (clk),
    .en    (en),
    .ea    (ea),
    .mu    (mu_cc),
    .len   (side[K_MU].len),
    .neg   (1'b0),
    .value (k_xx),
    .sat   (sat_xx)
  );

  tbs_stiff_lane u_kxy (
    .clk   (clk),
    .en    (en),
    .ea    (ea),
    .mu    (mu_cs),
    .len   (side[K_MU].len),
    .neg   (side[K_MU].sx ^ side[K_MU].sy),
    .value (k_xy),
    .sat   (sat_xy)
  );

  tbs_stiff_lane u_kyy (
    .clk   (clk),
    .en    (en),
    .ea    (ea),
    .mu    (mu_ss),
    .len   (side[K_MU].len),
    .neg   (1'b0),
    .value (k_yy),
    .sat   (sat_yy)
  );

  // output register; a zero-length bar shows only its flag
  always_ff @(posedge clk) begin
    if (en) begin
      if (side[K_STIFF].zero) begin
        o_len <= '0;
        o_cos <= '0;
        o_sin <= '0;
        o_xx  <= '0;
        o_xy  <= '0;
        o_yy  <= '0;
        o_sat <= 1'b0;
      end else begin
        o_len <= side[K_STIFF].len;
        o_cos <= side[K_STIFF].sx ? (~OUT_UNIT_W'(side[K_STIFF].cm) + OUT_UNIT_W'(1))
                                  : OUT_UNIT_W'(side[K_STIFF].cm);
        o_sin <= side[K_STIFF].sy ? (~OUT_UNIT_W'(side[K_STIFF].sm) + OUT_UNIT_W'(1))
                                  : OUT_UNIT_W'(side[K_STIFF].sm);
        o_xx  <= k_xx;
        o_xy  <= k_xy;
        o_yy  <= k_yy;
        o_sat <= sat_xx || sat_xy || sat_yy;
      end
      o_zero <= side[K_STIFF].zero;
    end
  end

  assign m_tvalid = vld[K_OUT];
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, o_yy, o_xy, o_xx, o_sin, o_cos, o_len};
  assign m_tuser  = {o_sat, o_zero};

endmodule
`default_nettype wire

// ===== rtl/tbs_checker.sv =====
`default_nettype none
module tbs_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [tbs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input wire logic [tbs_pkg::OUT_USER_W-1:0]  m_tuser
);
  import tbs_pkg::*;

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // empty output stage never blocks requests
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("request blocked with empty output");

  // zero-length bar gives all zeros and no clipping
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
    else $error("zero-length result not cleared");

  // cosine stays within plus or minus one
  a_cos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[65:34]) <= 32'sh4000_0000)
              && ($signed(m_tdata[65:34]) >= -32'sh4000_0000))
    else $error("cosine out of range");

endmodule

bind truss_bar_stiffness_core tbs_checker u_tbs_checker (.*);
`default_nettype wire

// ===== dv/truss_bar_stiffness_core_tb.sv =====
`timescale 1ns / 1ps
module truss_bar_stiffness_core_tb;
  import tbs_pkg::*;

  typedef struct {
    logic [LEN_W-1:0]      len;
    logic [OUT_UNIT_W-1:0] cosv;
    logic [OUT_UNIT_W-1:0] sinv;
    logic [STIFF_W-1:0]    kxx;
    logic [STIFF_W-1:0]    kxy;
    logic [STIFF_W-1:0]    kyy;
    logic                  zlen;
    logic                  sat;
  } bar_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  // Predictor copy of the registers
  logic [CFG_W-1:0] modulus_q;
  logic [CFG_W-1:0] area_q;

  bar_result_t bar_exp_q[$];
  int unsigned mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold_req;

  truss_bar_stiffness_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // One stiffness entry: E*A*mu / (len * 2^(60-F)), truncated, signed, clipped
  function automatic logic [STIFF_W-1:0] stiff_of(logic [63:0] ea, logic [63:0] mu,
                                                  logic neg, logic [LEN_W-1:0] len,
                                                  ref logic sat);
    logic [127:0] prod;
    logic [127:0] dvs;
    logic [127:0] quo;
    logic [127:0] limit;
    prod  = {64'd0, ea} * {64'd0, mu};
    dvs   = {94'd0, len} << STIFF_SHIFT;
    quo   = prod / dvs;
    limit = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
    if (quo > limit) begin
      sat = 1'b1;
      quo = limit;
    end
    return neg ? (~quo[63:0] + 64'd1) : quo[63:0];
  endfunction

  function automatic bar_result_t predict_bar(logic [31:0] x0, logic [31:0] y0,
                                              logic [31:0] x1, logic [31:0] y1);
    bar_result_t r;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic [67:0]        rad;
    logic [67:0]        cand;
    logic [33:0]        len;
    logic [63:0]        cm;
    logic [63:0]        sm;
    logic [63:0]        ea;
    logic               sat;
    dx = $signed({x1[31], x1}) - $signed({x0[31], x0});
    dy = $signed({y1[31], y1}) - $signed({y0[31], y0});
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    r = '{default: '0};
    if (ax == 0 && ay == 0) begin
      r.zlen = 1'b1;
      return r;
    end
    rad = {35'd0, ax} * {35'd0, ax} + {35'd0, ay} * {35'd0, ay};
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = {34'd0, len | (34'd1 << b)};
      if (cand * cand <= rad) len = len | (34'd1 << b);
    end
    cm = (({31'd0, ax} << 30) + {30'd0, len >> 1}) / {30'd0, len};
    sm = (({31'd0, ay} << 30) + {30'd0, len >> 1}) / {30'd0, len};
    ea = {32'd0, modulus_q} * {32'd0, area_q};
    sat = 1'b0;
    r.len  = len;
    r.cosv = dx[32] ? -cm[31:0] : cm[31:0];
    r.sinv = dy[32] ? -sm[31:0] : sm[31:0];
    r.kxx  = stiff_of(ea, cm * cm, 1'b0, len, sat);
    r.kxy  = stiff_of(ea, cm * sm, (dx[32] != dy[32]) && (cm * sm != 0), len, sat);
    r.kyy  = stiff_of(ea, sm * sm, 1'b0, len, sat);
    r.sat  = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: %s got %h want %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // Result checker
  always @(posedge clk) begin
    bar_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (bar_exp_q.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[63:0], 64'd0);
      end else begin
        want = bar_exp_q.pop_front();
        if (m_tdata[33:0] !== want.len)
          report_mismatch("bar_length", 64'(m_tdata[33:0]), 64'(want.len));
        if (m_tdata[65:34] !== want.cosv)
          report_mismatch("cosine", 64'(m_tdata[65:34]), 64'(want.cosv));
        if (m_tdata[97:66] !== want.sinv)
          report_mismatch("sine", 64'(m_tdata[97:66]), 64'(want.sinv));
        if (m_tdata[161:98] !== want.kxx) report_mismatch("stiff_xx", m_tdata[161:98], want.kxx);
        if (m_tdata[225:162] !== want.kxy)
          report_mismatch("stiff_xy", m_tdata[225:162], want.kxy);
        if (m_tdata[289:226] !== want.kyy)
          report_mismatch("stiff_yy", m_tdata[289:226], want.kyy);
        if (m_tuser[0] !== want.zlen)
          report_mismatch("zero_length", 64'(m_tuser[0]), 64'(want.zlen));
        if (m_tuser[1] !== want.sat)
          report_mismatch("saturated", 64'(m_tuser[1]), 64'(want.sat));
      end
    end
  end

  // Receiver: random backpressure, or a long counted hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_req) begin
        recv_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (400) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_bar(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1, logic [31:0] y1);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y1, x1, y0, x0};
    do @(posedge clk); while (!s_tready);
    bar_exp_q.push_back(predict_bar(x0, y0, x1, y1));
  endtask

  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    while (bar_exp_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MODULUS) modulus_q = val;
    else if (idx == CFG_AREA) area_q = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_material(logic [CFG_W-1:0] e, logic [CFG_W-1:0] a);
    wait_all_results();
    write_reg(CFG_MODULUS, e);
    write_reg(CFG_AREA, a);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
      2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
    endcase
  endfunction

  task automatic send_random_bar();
    logic [31:0] x0, y0, x1, y1;
    x0 = rand_coord();
    y0 = rand_coord();
    x1 = rand_coord();
    y1 = rand_coord();
    case ($urandom_range(19))
      0: begin x1 = x0; y1 = y0; end
      1: x1 = x0;
      2: y1 = y0;
      3: begin x1 = x0 + $urandom_range(3); y1 = y0 - $urandom_range(3); end
      default: ;
    endcase
    send_bar(x0, y0, x1, y1);
  endtask

  // Extremes and special cases, first with a unit material
  task automatic test_directed();
    set_material(32'h0001_0000, 32'h0001_0000);
    send_bar(32'd5, 32'd7, 32'd5, 32'd7);
    send_bar(0, 0, 0, 0);
    send_bar(0, 0, 32'h0001_0000, 0);
    send_bar(0, 0, 0, 32'h0001_0000);
    send_bar(0, 0, 32'hFFFF_0000, 0);
    send_bar(0, 0, 0, 32'hFFFF_0000);
    send_bar(0, 0, 32'h0003_0000, 32'h0004_0000);
    send_bar(0, 0, 32'hFFFD_0000, 32'h0004_0000);
    send_bar(0, 0, 32'h0003_0000, 32'hFFFC_0000);
    send_bar(0, 0, 32'd1, 0);
    send_bar(0, 0, 32'd1, 32'd1);
    send_bar(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_bar(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_bar(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_bar(32'h8000_0000, 0, 32'h7FFF_FFFF, 0);
    send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero modulus, then maximum material for clipping, then zero area
    set_material(32'd0, 32'hFFFF_FFFF);
    send_bar(0, 0, 32'd1, 32'd1);
    send_bar(0, 0, 32'h0002_0000, 32'h0005_0000);
    set_material(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(0, 0, 32'd1, 0);
    send_bar(0, 0, 32'd1, 32'hFFFF_FFFF);
    send_bar(0, 0, 32'd3, 32'd4);
    send_bar(0, 0, 32'h0001_0000, 32'h0001_0000);
    send_bar(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'd1);
    set_material(32'hFFFF_FFFF, 32'd0);
    send_bar(0, 0, 32'd1, 32'd1);
  endtask

  // Long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    set_material($urandom, $urandom_range(32'h0004_0000));
    send_idle_pct = 0;
    recv_hold_req = 1'b1;
    repeat (300) send_random_bar();
    wait_all_results();
  endtask

  task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      if (i % 110 == 0) begin
        case ($urandom_range(3))
          0: set_material($urandom, $urandom);
          1: set_material($urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000));
          2: set_material(32'hFFFF_FFFF, $urandom);
          default: set_material(32'h0001_0000, $urandom_range(32'h0001_0000));
        endcase
      end
      send_random_bar();
    end
  endtask

  initial begin
    mismatch_cnt  = 0;
    modulus_q     = '0;
    area_q        = '0;
    send_idle_pct = 17;
    recv_idle_pct = 55;
    recv_hold_req = 1'b0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(440, 17, 55);
    test_backpressure();
    test_random(440, 55, 17);
    test_random(440, 0, 0);
    wait_all_results();

    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
